// ===== rtl/core/ccr_pkg.sv =====
package ccr_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int MIN_STEPS     = 4;
  localparam int VW            = 66;   // working width of signed intermediates

  typedef logic signed [VW-1:0] val_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SQX, OP_SQY, OP_RT1, OP_RT2, OP_QDIV, OP_UMUL, OP_UDIV,
    OP_M1, OP_M2, OP_M3, OP_M4, OP_D4, OP_M5, OP_D5, OP_M6, OP_D6
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_SQX, ST_SQY, ST_RT1, ST_RT2, ST_CHECK, ST_Q,
    ST_U_MUL, ST_U_DIV, ST_M1, ST_M2, ST_M3, ST_M4, ST_D4, ST_M5, ST_D5,
    ST_M6, ST_D6, ST_EMIT, ST_EMIT_P2
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       start;
    logic       load;
    logic       i_clr;
    logic       i_inc;
    logic       emit;
    logic       emit_p2;
    logic       p2_deg;
    logic [1:0] k;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic small_n;
    logic deg;
    logic i_last;
  } sts_t;

  function automatic val_t sext32(input logic signed [31:0] v);
    sext32 = {{(VW-32){v[31]}}, v};
  endfunction

  function automatic logic [VW-1:0] abs_val(input val_t v);
    abs_val = v[VW-1] ? -v : v;
  endfunction

  function automatic logic [31:0] sat32(input val_t v);
    if (v > val_t'(64'sh7fffffff)) begin
      sat32 = 32'h7fffffff;
    end else if (v < -val_t'(64'sh80000000)) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/ccr_mul.sv =====
module ccr_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ccr_pkg::val_t a,
  input  ccr_pkg::val_t b,
  output logic          done,
  output logic [79:0]   prod_mag,
  output logic          prod_neg
);
  import ccr_pkg::*;

  // 40x8 per cycle, top byte of b first
  logic [39:0] a_r, b_r;
  logic [79:0] acc_r;
  logic [2:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic [VW-1:0] a_abs, b_abs;
  logic [47:0] part;

  always_comb begin
    a_abs = abs_val(a);
    b_abs = abs_val(b);
    part  = a_r * b_r[39:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_abs[39:0];
      b_r   <= b_abs[39:0];
      neg_r <= a[VW-1] ^ b[VW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[71:0], 8'd0} + {32'd0, part};
      b_r   <= {b_r[31:0], 8'd0};
    end
  end

  assign done     = done_r;
  assign prod_mag = acc_r;
  assign prod_neg = neg_r;

endmodule

// ===== rtl/core/ccr_div.sv =====
module ccr_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ccr_pkg::val_t num,
  input  logic [33:0]   den,
  output logic          done,
  output ccr_pkg::val_t quo
);
  import ccr_pkg::*;

  // restoring, one quotient bit per cycle; truncates toward zero
  logic [64:0] num_r;
  logic [33:0] rem_r, den_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic [VW-1:0] num_abs;
  logic [34:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    num_abs = abs_val(num);
    rem_sh  = {rem_r, num_r[64]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num_abs[64:0];
      den_r <= den;
      rem_r <= '0;
      neg_r <= num[VW-1];
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[33:0] : rem_sh[33:0];
      num_r <= {num_r[63:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -val_t'({1'b0, num_r}) : val_t'({1'b0, num_r});

endmodule

// ===== rtl/core/ccr_sqrt.sv =====
module ccr_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [65:0]   rad,
  output logic          done,
  output logic [32:0]   root
);

  // digit-by-digit floor root, two radicand bits per cycle
  logic [65:0] rad_r;
  logic [34:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [36:0] rem_sh, trial, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[65:64]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[63:0], 2'b00};
      rem_r  <= ge ? diff[34:0] : rem_sh[34:0];
      root_r <= {root_r[31:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/ccr_dp.sv =====
module ccr_dp #(
  parameter int MAX_STEPS = ccr_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ccr_pkg::cmd_t      cmd,
  output ccr_pkg::sts_t      sts,
  input  logic signed [31:0] in_p0_x,
  input  logic signed [31:0] in_p0_y,
  input  logic signed [31:0] in_p1_x,
  input  logic signed [31:0] in_p1_y,
  input  logic signed [31:0] in_p2_x,
  input  logic signed [31:0] in_p2_y,
  input  logic signed [31:0] in_p3_x,
  input  logic signed [31:0] in_p3_y,
  input  logic [15:0]        in_step_count,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic               out_last,
  output logic               out_degenerate
);
  import ccr_pkg::*;

  localparam int NW = $clog2(MAX_STEPS + 1);

  logic signed [31:0] p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  logic [NW-1:0] n_r, i_r;
  logic [65:0]   ssq_r;
  logic [32:0]   dist_r, d0_r, d1_r, d2_r;
  val_t q0x_r, q0y_r, q1x_r, q1y_r, q2x_r, q2y_r;
  val_t tmp_r, u_r, a1_r, a2_r, a3_r, b1_r, b2_r, cx_r, cy_r;
  logic [31:0] ox_r, oy_r;
  logic        olast_r, odeg_r;

  val_t p1a, p2a, q0a, q1a, q2a, gx, gy, gdiff, qdiff;
  val_t d0v, d1v, mul_a, mul_b, div_num, prods, t16;
  logic [33:0] div_den, dk;
  logic [65:0] rt_rad;
  logic        is_mul, is_div, is_rt;
  logic        mul_done, div_done, rt_done, mul_neg;
  logic [79:0] mul_mag;
  val_t        quo;
  logic [32:0] root;
  logic [NW-1:0] n_sat;

  always_comb begin
    d0v = val_t'(d0_r);
    d1v = val_t'(d1_r);
    p1a = cmd.axis ? sext32(p1y_r) : sext32(p1x_r);
    p2a = cmd.axis ? sext32(p2y_r) : sext32(p2x_r);
    q0a = cmd.axis ? q0y_r : q0x_r;
    q1a = cmd.axis ? q1y_r : q1x_r;
    q2a = cmd.axis ? q2y_r : q2x_r;

    unique case (cmd.k)
      2'd0: begin
        gx = sext32(p1x_r) - sext32(p0x_r);
        gy = sext32(p1y_r) - sext32(p0y_r);
        dk = {1'b0, d0_r};
      end
      2'd1: begin
        gx = sext32(p2x_r) - sext32(p1x_r);
        gy = sext32(p2y_r) - sext32(p1y_r);
        dk = {1'b0, d1_r};
      end
      default: begin
        gx = sext32(p3x_r) - sext32(p2x_r);
        gy = sext32(p3y_r) - sext32(p2y_r);
        dk = {1'b0, d2_r};
      end
    endcase
    gdiff = cmd.axis ? gy : gx;
    // first slope runs from P1 back to P0
    qdiff = (cmd.k == 2'd0) ? -gdiff : gdiff;

    is_mul = 1'b0;
    is_div = 1'b0;
    is_rt  = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    div_num = tmp_r;
    div_den = {1'b0, d1_r};
    rt_rad  = ssq_r;
    unique case (cmd.op)
      OP_SQX:  begin is_mul = 1'b1; mul_a = gx; mul_b = gx; end
      OP_SQY:  begin is_mul = 1'b1; mul_a = gy; mul_b = gy; end
      OP_RT1:  begin is_rt = 1'b1; rt_rad = ssq_r; end
      OP_RT2:  begin is_rt = 1'b1; rt_rad = {17'd0, dist_r, 16'd0}; end
      OP_QDIV: begin is_div = 1'b1; div_num = qdiff <<< 16; div_den = dk; end
      OP_UMUL: begin is_mul = 1'b1; mul_a = val_t'(i_r); mul_b = d1v; end
      OP_UDIV: begin is_div = 1'b1; div_den = 34'(n_r); end
      OP_M1:   begin is_mul = 1'b1; mul_a = q0a; mul_b = u_r; end
      OP_M2:   begin is_mul = 1'b1; mul_a = q1a; mul_b = u_r; end
      OP_M3:   begin is_mul = 1'b1; mul_a = q2a; mul_b = u_r - d1v; end
      OP_M4:   begin is_mul = 1'b1; mul_a = a2_r - a1_r; mul_b = u_r + d0v; end
      OP_D4:   begin is_div = 1'b1; div_den = {1'b0, d0_r} + {1'b0, d1_r}; end
      OP_M5:   begin is_mul = 1'b1; mul_a = a3_r - a2_r; mul_b = u_r; end
      OP_D5:   begin is_div = 1'b1; div_den = {1'b0, d1_r} + {1'b0, d2_r}; end
      OP_M6:   begin is_mul = 1'b1; mul_a = b2_r - b1_r; mul_b = u_r; end
      OP_D6:   begin is_div = 1'b1; div_den = {1'b0, d1_r}; end
      default: ;
    endcase

    prods = mul_neg ? -val_t'({1'b0, mul_mag[64:0]}) : val_t'({1'b0, mul_mag[64:0]});
    // product / 2^16 truncated toward zero
    t16   = mul_neg ? -val_t'({16'd0, mul_mag[65:16]}) : val_t'({16'd0, mul_mag[65:16]});

    n_sat = (in_step_count > 16'(MAX_STEPS)) ? NW'(MAX_STEPS) : in_step_count[NW-1:0];
  end

  ccr_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.start & is_mul), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod_mag(mul_mag), .prod_neg(mul_neg)
  );

  ccr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start & is_div), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  ccr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.start & is_rt), .rad(rt_rad),
    .done(rt_done), .root(root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0x_r <= in_p0_x; p0y_r <= in_p0_y;
      p1x_r <= in_p1_x; p1y_r <= in_p1_y;
      p2x_r <= in_p2_x; p2y_r <= in_p2_y;
      p3x_r <= in_p3_x; p3y_r <= in_p3_y;
      n_r   <= n_sat;
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + NW'(1);
    end
    if (sts.done) begin
      unique case (cmd.op)
        OP_SQX:  ssq_r  <= mul_mag[65:0];
        OP_SQY:  ssq_r  <= ssq_r + mul_mag[65:0];
        OP_RT1:  dist_r <= root;
        OP_RT2: begin
          unique case (cmd.k)
            2'd0:    d0_r <= root;
            2'd1:    d1_r <= root;
            default: d2_r <= root;
          endcase
        end
        OP_QDIV: begin
          unique case ({cmd.k, cmd.axis})
            3'b000:  q0x_r <= quo;
            3'b001:  q0y_r <= quo;
            3'b010:  q1x_r <= quo;
            3'b011:  q1y_r <= quo;
            3'b100:  q2x_r <= quo;
            default: q2y_r <= quo;
          endcase
        end
        OP_UMUL: tmp_r <= prods;
        OP_UDIV: u_r   <= quo;
        OP_M1:   a1_r  <= p1a - t16;
        OP_M2:   a2_r  <= p1a + t16;
        OP_M3:   a3_r  <= p2a + t16;
        OP_M4:   tmp_r <= prods;
        OP_D4:   b1_r  <= a1_r + quo;
        OP_M5:   tmp_r <= prods;
        OP_D5:   b2_r  <= a2_r + quo;
        OP_M6:   tmp_r <= prods;
        OP_D6: begin
          if (cmd.axis) cy_r <= b1_r + quo;
          else          cx_r <= b1_r + quo;
        end
        default: ;
      endcase
    end
    if (cmd.emit) begin
      if (cmd.emit_p2) begin
        ox_r    <= p2x_r;
        oy_r    <= p2y_r;
        olast_r <= 1'b1;
        odeg_r  <= cmd.p2_deg;
      end else begin
        ox_r    <= sat32(cx_r);
        oy_r    <= sat32(cy_r);
        olast_r <= (i_r == n_r - NW'(1));
        odeg_r  <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.done    = mul_done | div_done | rt_done;
    sts.small_n = n_r < NW'(MIN_STEPS);
    sts.deg     = (d0_r == '0) | (d1_r == '0) | (d2_r == '0);
    sts.i_last  = (i_r == n_r - NW'(1));
  end

  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_last       = olast_r;
  assign out_degenerate = odeg_r;

endmodule

// ===== rtl/core/ccr_ctrl.sv =====
module ccr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ccr_pkg::cmd_t cmd,
  input  ccr_pkg::sts_t sts
);
  import ccr_pkg::*;

  state_t     state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic [1:0] k_r, k_nxt;
  logic       axis_r, axis_nxt;
  logic       ov_r, ov_nxt;
  logic       adv, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      k_r      <= '0;
      axis_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      k_r      <= k_nxt;
      axis_r   <= axis_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    k_nxt      = k_r;
    axis_nxt   = axis_r;
    ov_nxt     = ov_r & ~out_ready;
    out_free   = ~ov_r | out_ready;
    in_ready   = 1'b0;
    adv        = 1'b0;
    cmd        = '0;
    cmd.k      = k_r;
    cmd.axis   = axis_r;

    unique case (state_r)
      ST_SQX:   cmd.op = OP_SQX;
      ST_SQY:   cmd.op = OP_SQY;
      ST_RT1:   cmd.op = OP_RT1;
      ST_RT2:   cmd.op = OP_RT2;
      ST_Q:     cmd.op = OP_QDIV;
      ST_U_MUL: cmd.op = OP_UMUL;
      ST_U_DIV: cmd.op = OP_UDIV;
      ST_M1:    cmd.op = OP_M1;
      ST_M2:    cmd.op = OP_M2;
      ST_M3:    cmd.op = OP_M3;
      ST_M4:    cmd.op = OP_M4;
      ST_D4:    cmd.op = OP_D4;
      ST_M5:    cmd.op = OP_M5;
      ST_D5:    cmd.op = OP_D5;
      ST_M6:    cmd.op = OP_M6;
      ST_D6:    cmd.op = OP_D6;
      default:  cmd.op = OP_NONE;
    endcase

    // kick the unit once, then hold the op until it reports done
    if (cmd.op != OP_NONE) begin
      if (!issued_r) begin
        cmd.start  = 1'b1;
        issued_nxt = 1'b1;
      end else if (sts.done) begin
        issued_nxt = 1'b0;
        adv        = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        k_nxt = '0;
        state_nxt = sts.small_n ? ST_EMIT_P2 : ST_SQX;
      end
      ST_SQX: if (adv) state_nxt = ST_SQY;
      ST_SQY: if (adv) state_nxt = ST_RT1;
      ST_RT1: if (adv) state_nxt = ST_RT2;
      ST_RT2: begin
        if (adv) begin
          if (k_r == 2'd2) begin
            state_nxt = ST_CHECK;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_SQX;
          end
        end
      end
      ST_CHECK: begin
        k_nxt     = '0;
        axis_nxt  = 1'b0;
        state_nxt = sts.deg ? ST_EMIT_P2 : ST_Q;
      end
      ST_Q: begin
        if (adv) begin
          axis_nxt = ~axis_r;
          if (axis_r) begin
            if (k_r == 2'd2) begin
              cmd.i_clr = 1'b1;
              state_nxt = ST_U_MUL;
            end else begin
              k_nxt = k_r + 2'd1;
            end
          end
        end
      end
      ST_U_MUL: if (adv) state_nxt = ST_U_DIV;
      ST_U_DIV: begin
        if (adv) begin
          axis_nxt  = 1'b0;
          state_nxt = ST_M1;
        end
      end
      ST_M1: if (adv) state_nxt = ST_M2;
      ST_M2: if (adv) state_nxt = ST_M3;
      ST_M3: if (adv) state_nxt = ST_M4;
      ST_M4: if (adv) state_nxt = ST_D4;
      ST_D4: if (adv) state_nxt = ST_M5;
      ST_M5: if (adv) state_nxt = ST_D5;
      ST_D5: if (adv) state_nxt = ST_M6;
      ST_M6: if (adv) state_nxt = ST_D6;
      ST_D6: begin
        if (adv) begin
          if (axis_r) begin
            state_nxt = ST_EMIT;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = ST_M1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          ov_nxt   = 1'b1;
          if (sts.i_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = ST_U_MUL;
          end
        end
      end
      ST_EMIT_P2: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.emit_p2 = 1'b1;
          cmd.p2_deg  = ~sts.small_n;
          ov_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

endmodule

// ===== rtl/core/centripetal_catmull_rom_points_core.sv =====
// Centripetal Catmull-Rom sampler. Each input word carries four Q16.16 control
// points and a step count n (saturated to MAX_STEPS); the block returns n curve
// points between P2's predecessor P1 and P2, the last one flagged, or P2 alone
// when n is under four or two consecutive points coincide (the latter sets degenerate=1).
// Work is sequential through one iterative multiplier (8 bits/cycle), one
// restoring divider (1 bit/cycle) and one square-root unit (2 bits/cycle).
// Setup of knots and slopes runs first, then each point in turn. The next word
// is taken once the last point has been loaded into the output register.
module centripetal_catmull_rom_points_core #(
  parameter int MAX_STEPS = ccr_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_p0_x,
  input  logic signed [31:0] in_p0_y,
  input  logic signed [31:0] in_p1_x,
  input  logic signed [31:0] in_p1_y,
  input  logic signed [31:0] in_p2_x,
  input  logic signed [31:0] in_p2_y,
  input  logic signed [31:0] in_p3_x,
  input  logic signed [31:0] in_p3_y,
  input  logic [15:0]        in_step_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic               out_last,
  output logic               out_degenerate
);
  import ccr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  ccr_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_p0_x(in_p0_x), .in_p0_y(in_p0_y), .in_p1_x(in_p1_x), .in_p1_y(in_p1_y),
    .in_p2_x(in_p2_x), .in_p2_y(in_p2_y), .in_p3_x(in_p3_x), .in_p3_y(in_p3_y),
    .in_step_count(in_step_count),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_last(out_last), .out_degenerate(out_degenerate)
  );

endmodule

// ===== rtl/core/ccr_chk.sv =====
module ccr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_point_x,
  input logic [31:0] out_point_y,
  input logic        out_last,
  input logic        out_degenerate
);

  // a degenerate word is always the only word of its item
  a_deg_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_last)
    else $error("degenerate word without last");

  // the block does not accept a second word directly after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x)
      && $stable(out_point_y) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind centripetal_catmull_rom_points_core ccr_chk u_ccr_chk (.*);
